// File: rtl/bsf_pkg.sv
// Shared types and constants for the BMP stream to framebuffer block.
// No dependencies; every other file in rtl/ depends on this package.
package bsf_pkg;

  // Default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 480;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int DIM_W      = 16;
  localparam int COLOR_W    = 24;
  localparam int INDEX_W    = 19;
  localparam int ORIGIN_X_W = 10;
  localparam int ORIGIN_Y_W = 9;
  localparam int HDR_CNT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // BMP header layout, byte offsets within the file
  localparam logic [HDR_CNT_W-1:0] HDR_BYTES    = 6'd54;
  localparam logic [HDR_CNT_W-1:0] HDR_WIDTH_LO = 6'd18;
  localparam logic [HDR_CNT_W-1:0] HDR_WIDTH_HI = 6'd19;
  localparam logic [HDR_CNT_W-1:0] HDR_HGT_LO   = 6'd22;
  localparam logic [HDR_CNT_W-1:0] HDR_HGT_HI   = 6'd23;
  localparam logic [HDR_CNT_W-1:0] HDR_BPP_LO   = 6'd28;
  localparam logic [HDR_CNT_W-1:0] HDR_BPP_HI   = 6'd29;
  localparam logic [BYTE_W-1:0]    BPP_32       = 8'd32;

  // Byte position inside one pixel
  typedef enum logic [1:0] {
    PX_BLUE  = 2'd0,
    PX_GREEN = 2'd1,
    PX_RED   = 2'd2,
    PX_PAD   = 2'd3
  } px_phase_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1
  } cfg_reg_t;

  // Pixel data carried from the parser to the address stage
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } pix_payload_t;

endpackage

// File: rtl/bsf_if.sv
// Valid/ready channel interfaces: file byte input, pixel write output and
// configuration write. Depends on bsf_pkg for field widths.
interface bsf_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsf_pkg::BYTE_W-1:0]  file_byte;
  logic                        start_of_file;
  modport source (output valid, file_byte, start_of_file, input ready);
  modport sink   (input valid, file_byte, start_of_file, output ready);
endinterface

interface bsf_out_if;
  logic                         valid;
  logic                         ready;
  logic [bsf_pkg::INDEX_W-1:0]  pixel_index;
  logic [bsf_pkg::COLOR_W-1:0]  color;
  logic                         last_pixel;
  modport source (output valid, pixel_index, color, last_pixel, input ready);
  modport sink   (input valid, pixel_index, color, last_pixel, output ready);
endinterface

interface bsf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bsf_pkg::CFG_IDX_W-1:0]   index;
  logic [bsf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bmp_stream_to_framebuffer.sv
// Top level of the BMP stream to framebuffer block: configuration registers,
// parser and address stage. Depends on bsf_pkg, bsf_if, bsf_parser, bsf_addr.
//
// Usage:
//   in_bus  - one BMP file byte per request, start_of_file on byte 0 of a file.
//   out_bus - one framebuffer write per on-screen pixel: pixel_index,
//             color (red, green, blue) and last_pixel on the image's end.
//   cfg_bus - register writes: index 0 origin_x, index 1 origin_y. Always
//             ready; write only while no pixel is in flight.
// Throughput: one byte per cycle while out_bus is not stalled. Each byte needs one pass through
//   the parser (counters and a 17-bit add/compare) and each pixel one pass
//   through the address stage (row times constant screen width plus column).
// Path: once its red byte is accepted, a pixel is held in the pixel stage
//   and then in the output register, which drives out_bus.
// Reset: clears the origin and all parse state; the stream is parsed as if a
//   file had just begun. Nothing is pending on out_bus after reset.
// Stall: with out_bus stalled the output register and the pixel stage still
//   hold two pixels; in_bus.ready drops only when both are full.
module bmp_stream_to_framebuffer #(
  parameter int SCREEN_WIDTH  = bsf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bsf_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  bsf_in_if.sink   in_bus,
  bsf_out_if.source out_bus,
  bsf_cfg_if.sink  cfg_bus
);
  import bsf_pkg::*;

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);

  logic [ORIGIN_X_W-1:0] origin_x_r;
  logic [ORIGIN_Y_W-1:0] origin_y_r;
  logic                  pix_valid;
  logic                  pix_ready;
  logic [XW-1:0]         pix_x;
  logic [YW-1:0]         pix_y;
  pix_payload_t          pix_data;

  // Configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_ORIGIN_X: origin_x_r <= cfg_bus.data[ORIGIN_X_W-1:0];
        CFG_ORIGIN_Y: origin_y_r <= cfg_bus.data[ORIGIN_Y_W-1:0];
        default:      ;
      endcase
    end
  end

  bsf_parser #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_bus.valid),
    .in_ready      (in_bus.ready),
    .file_byte     (in_bus.file_byte),
    .start_of_file (in_bus.start_of_file),
    .origin_x      (origin_x_r),
    .origin_y      (origin_y_r),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix_x         (pix_x),
    .pix_y         (pix_y),
    .pix_data      (pix_data)
  );

  bsf_addr #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_addr (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .pix_data    (pix_data),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .pixel_index (out_bus.pixel_index),
    .color       (out_bus.color),
    .last_pixel  (out_bus.last_pixel)
  );

  // Input backpressure comes only from a full pipeline behind a stalled output
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (out_bus.valid && !out_bus.ready && pix_valid))
    else $error("input stalled while the pipeline had room");

  // A start mark is a header byte and never yields a pixel
  a_start_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.start_of_file) |=> !pix_valid)
    else $error("pixel produced from a start-of-file byte");

  // Every write lands inside the framebuffer
  a_index_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> ((SCREEN_WIDTH * SCREEN_HEIGHT > (1 << INDEX_W)) ||
      (int'(out_bus.pixel_index) < SCREEN_WIDTH * SCREEN_HEIGHT)))
    else $error("pixel index beyond the framebuffer");

endmodule

// File: rtl/bsf_parser.sv
// Header and pixel parser: walks the byte stream, assembles pixels, maps
// them to screen coordinates and holds them in the pixel stage register.
// Depends on bsf_pkg.
module bsf_parser #(
  parameter int SCREEN_WIDTH  = bsf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bsf_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bsf_pkg::BYTE_W-1:0]          file_byte,
  input  logic                                start_of_file,
  input  logic [bsf_pkg::ORIGIN_X_W-1:0]      origin_x,
  input  logic [bsf_pkg::ORIGIN_Y_W-1:0]      origin_y,
  output logic                                pix_valid,
  input  logic                                pix_ready,
  output logic [$clog2(SCREEN_WIDTH)-1:0]     pix_x,
  output logic [$clog2(SCREEN_HEIGHT)-1:0]    pix_y,
  output bsf_pkg::pix_payload_t               pix_data
);
  import bsf_pkg::*;

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam int SW = DIM_W + 1;  // screen sums before the range check

  // Parse state
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt, hdr_cnt_c;
  logic [DIM_W-1:0]     width_r, width_nxt, width_c;
  logic [DIM_W-1:0]     height_r, height_nxt, height_c;
  logic                 depth32_r, depth32_nxt, depth32_c;
  px_phase_t            phase_r, phase_nxt, phase_c;
  logic [BYTE_W-1:0]    blue_r, blue_nxt, blue_c;
  logic [BYTE_W-1:0]    green_r, green_nxt, green_c;
  logic [DIM_W-1:0]     col_r, col_nxt, col_c;
  logic [DIM_W-1:0]     row_r, row_nxt, row_c;
  logic                 done_r, done_nxt, done_c;

  // Pixel stage
  logic                 pix_valid_r;
  logic [XW-1:0]        pix_x_r;
  logic [YW-1:0]        pix_y_r;
  pix_payload_t         pix_data_r;

  logic                 accept;
  logic                 emit;
  logic                 is_red;
  logic                 last;
  logic [SW-1:0]        sx_full, sy_full, col_inc;
  logic [DIM_W-1:0]     flip_row;

  assign in_ready = !pix_valid_r || pix_ready;
  assign accept   = in_valid && in_ready;

  // A start mark clears parsing before its byte is used
  always_comb begin
    hdr_cnt_c = start_of_file ? '0 : hdr_cnt_r;
    width_c   = start_of_file ? '0 : width_r;
    height_c  = start_of_file ? '0 : height_r;
    depth32_c = start_of_file ? 1'b0 : depth32_r;
    phase_c   = start_of_file ? PX_BLUE : phase_r;
    blue_c    = start_of_file ? '0 : blue_r;
    green_c   = start_of_file ? '0 : green_r;
    col_c     = start_of_file ? '0 : col_r;
    row_c     = start_of_file ? '0 : row_r;
    done_c    = start_of_file ? 1'b0 : done_r;
  end

  // Screen mapping: rows flipped, then offset by the origin
  always_comb begin
    flip_row = height_c - DIM_W'(1) - row_c;
    sx_full  = SW'(origin_x) + SW'(col_c);
    sy_full  = SW'(origin_y) + SW'(flip_row);
    col_inc  = SW'(col_c) + SW'(1);
    last     = (col_c == width_c - DIM_W'(1)) && (row_c == height_c - DIM_W'(1));
    emit     = (sx_full < SW'(SCREEN_WIDTH)) && (sy_full < SW'(SCREEN_HEIGHT));
  end

  // Next parse state
  always_comb begin
    hdr_cnt_nxt = hdr_cnt_c;
    width_nxt   = width_c;
    height_nxt  = height_c;
    depth32_nxt = depth32_c;
    phase_nxt   = phase_c;
    blue_nxt    = blue_c;
    green_nxt   = green_c;
    col_nxt     = col_c;
    row_nxt     = row_c;
    done_nxt    = done_c;
    is_red      = 1'b0;
    if (hdr_cnt_c < HDR_BYTES) begin
      hdr_cnt_nxt = hdr_cnt_c + HDR_CNT_W'(1);
      case (hdr_cnt_c)
        HDR_WIDTH_LO: width_nxt   = {width_c[DIM_W-1:BYTE_W], file_byte};
        HDR_WIDTH_HI: width_nxt   = {file_byte, width_c[BYTE_W-1:0]};
        HDR_HGT_LO:   height_nxt  = {height_c[DIM_W-1:BYTE_W], file_byte};
        HDR_HGT_HI:   height_nxt  = {file_byte, height_c[BYTE_W-1:0]};
        HDR_BPP_LO:   depth32_nxt = (file_byte == BPP_32);
        HDR_BPP_HI:   depth32_nxt = depth32_c && (file_byte == '0);
        default:      ;
      endcase
    end else if (!done_c && width_c != '0 && height_c != '0) begin
      case (phase_c)
        PX_BLUE: begin
          blue_nxt  = file_byte;
          phase_nxt = PX_GREEN;
        end
        PX_GREEN: begin
          green_nxt = file_byte;
          phase_nxt = PX_RED;
        end
        PX_PAD: phase_nxt = PX_BLUE;
        default: begin
          // red byte completes the pixel
          is_red    = 1'b1;
          phase_nxt = depth32_c ? PX_PAD : PX_BLUE;
          if (col_inc >= SW'(width_c)) begin
            col_nxt = '0;
            row_nxt = row_c + DIM_W'(1);
          end else begin
            col_nxt = col_inc[DIM_W-1:0];
          end
          if (last) begin
            done_nxt  = 1'b1;
            phase_nxt = PX_BLUE;
          end
        end
      endcase
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= '0;
      width_r   <= '0;
      height_r  <= '0;
      depth32_r <= 1'b0;
      phase_r   <= PX_BLUE;
      blue_r    <= '0;
      green_r   <= '0;
      col_r     <= '0;
      row_r     <= '0;
      done_r    <= 1'b0;
    end else if (accept) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      depth32_r <= depth32_nxt;
      phase_r   <= phase_nxt;
      blue_r    <= blue_nxt;
      green_r   <= green_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      done_r    <= done_nxt;
    end
  end

  // Pixel stage register; off-screen pixels never enter it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_ready) begin
      pix_valid_r <= accept && is_red && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_x_r          <= sx_full[XW-1:0];
      pix_y_r          <= sy_full[YW-1:0];
      pix_data_r.color <= {file_byte, green_c, blue_c};
      pix_data_r.last  <= last;
    end
  end

  assign pix_valid = pix_valid_r;
  assign pix_x     = pix_x_r;
  assign pix_y     = pix_y_r;
  assign pix_data  = pix_data_r;

endmodule

// File: rtl/bsf_addr.sv
// Address stage: turns screen coordinates into a framebuffer word index
// and holds the result in the output register. Depends on bsf_pkg.
module bsf_addr #(
  parameter int SCREEN_WIDTH  = bsf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bsf_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pix_valid,
  output logic                                pix_ready,
  input  logic [$clog2(SCREEN_WIDTH)-1:0]     pix_x,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0]    pix_y,
  input  bsf_pkg::pix_payload_t               pix_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bsf_pkg::INDEX_W-1:0]         pixel_index,
  output logic [bsf_pkg::COLOR_W-1:0]         color,
  output logic                                last_pixel
);
  import bsf_pkg::*;

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam int IW = XW + YW;  // holds any row * width + column on screen

  logic               out_valid_r;
  logic [INDEX_W-1:0] index_r;
  logic [COLOR_W-1:0] color_r;
  logic               last_r;
  logic [IW-1:0]      index_full;

  assign pix_ready = !out_valid_r || out_ready;

  // Constant-stride address
  assign index_full = IW'(pix_y) * IW'(SCREEN_WIDTH) + IW'(pix_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_ready) begin
      out_valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      index_r <= INDEX_W'(index_full);
      color_r <= pix_data.color;
      last_r  <= pix_data.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign pixel_index = index_r;
  assign color       = color_r;
  assign last_pixel  = last_r;

endmodule

// File: sim/tb.sv
// Self-checking bench for bmp_stream_to_framebuffer: streams BMP files and checks each
// framebuffer write against an in-bench parser. Depends on rtl/bsf_pkg.sv and rtl/bsf_if.sv.
`timescale 1ns / 100ps

module tb;
  import bsf_pkg::*;

  localparam int SCR_W        = SCREEN_WIDTH_DEF;
  localparam int SCR_H        = SCREEN_HEIGHT_DEF;
  localparam int BPP_24       = 24;
  localparam int BPP_32_ONLY  = 32;
  localparam int BPP_32_HIGH  = 16'h0120;  // low byte 32, high byte nonzero
  localparam int IDLE_PCT     = 72;
  localparam int BOTH_PCT     = 32;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_BYTES  = 100;
  localparam int RAND_PHASES  = 8;
  localparam int TAIL_GAP     = 6;       // pipeline is two deep, leave some margin
  localparam int SETTLE_LIMIT = 50000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {MIX_NONE, MIX_SEND, MIX_RECV, MIX_BOTH} idle_mix_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              sof;
  } bmp_byte_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } fb_write_t;

  logic clk = 1'b0;
  logic rst_n;

  bsf_in_if  in_bus ();
  bsf_out_if out_bus ();
  bsf_cfg_if cfg_bus ();

  bmp_stream_to_framebuffer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench-side copy of registers and parse state
  logic [ORIGIN_X_W-1:0] org_x;
  logic [ORIGIN_Y_W-1:0] org_y;
  int unsigned           hdr_seen;
  logic [DIM_W-1:0]      img_w, img_h;
  logic                  is_32bpp;
  px_phase_t             px_pos;
  logic [BYTE_W-1:0]     blue_b, green_b;
  logic [DIM_W-1:0]      col_pos, row_pos;
  logic                  img_finished;

  bmp_byte_t bytes_to_send[$];
  fb_write_t pixel_writes_due[$];
  bmp_byte_t next_byte;
  fb_write_t seen_write, due_write;

  int bytes_queued   = 0;
  int bytes_taken    = 0;
  int files_sent     = 0;
  int pixels_checked = 0;
  int settings_used  = 0;
  int errors         = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req_cnt   = 0;
  int hold_seen_cnt  = 0;
  int hold_left      = 0;
  logic hold_on      = 1'b0;

  function automatic void clear_parse();
    hdr_seen     = 0;
    img_w        = '0;
    img_h        = '0;
    is_32bpp     = 1'b0;
    px_pos       = PX_BLUE;
    blue_b       = '0;
    green_b      = '0;
    col_pos      = '0;
    row_pos      = '0;
    img_finished = 1'b0;
  endfunction

  // Advance the parse by one accepted byte; queue the write it produces, if any
  function automatic void parse_file_byte(input logic [BYTE_W-1:0] b, input logic sof);
    logic [31:0] sx, sy;
    logic        at_end;
    fb_write_t   wr;
    if (sof) clear_parse();
    if (hdr_seen < int'(HDR_BYTES)) begin
      case (hdr_seen)
        HDR_WIDTH_LO: img_w[7:0]  = b;
        HDR_WIDTH_HI: img_w[15:8] = b;
        HDR_HGT_LO:   img_h[7:0]  = b;
        HDR_HGT_HI:   img_h[15:8] = b;
        HDR_BPP_LO:   is_32bpp = (b == BPP_32);
        HDR_BPP_HI:   is_32bpp = is_32bpp && (b == 8'd0);
        default: ;
      endcase
      hdr_seen++;
      return;
    end
    if (img_finished || img_w == '0 || img_h == '0) return;
    case (px_pos)
      PX_BLUE: begin
        blue_b = b;
        px_pos = PX_GREEN;
      end
      PX_GREEN: begin
        green_b = b;
        px_pos  = PX_RED;
      end
      PX_PAD: px_pos = PX_BLUE;
      default: begin
        // red byte closes the pixel; file rows are bottom-up
        sx = 32'(org_x) + 32'(col_pos);
        sy = 32'(org_y) + 32'(img_h) - 32'd1 - 32'(row_pos);
        at_end = (col_pos == img_w - 16'd1) && (row_pos == img_h - 16'd1);
        px_pos = is_32bpp ? PX_PAD : PX_BLUE;
        if (32'(col_pos) + 32'd1 >= 32'(img_w)) begin
          col_pos = '0;
          row_pos = row_pos + 16'd1;
        end else begin
          col_pos = col_pos + 16'd1;
        end
        if (at_end) begin
          img_finished = 1'b1;
          px_pos       = PX_BLUE;
        end
        if (sx < 32'(SCR_W) && sy < 32'(SCR_H)) begin
          wr.index = INDEX_W'(sy * 32'(SCR_W) + sx);
          wr.color = {b, green_b, blue_b};
          wr.last  = at_end;
          pixel_writes_due.push_back(wr);
        end
      end
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7, 0))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic sof);
    bytes_to_send.push_back({b, sof});
    bytes_queued++;
  endfunction

  // One BMP file: header, pixel data (cut to keep bytes if 0 <= keep < full length), then stray bytes
  function automatic void queue_bmp(input int w, input int h, input int bpp, input bit mark,
                                    input longint keep, input int tail);
    longint            data_len;
    logic [BYTE_W-1:0] b;
    data_len = longint'(w) * longint'(h) * ((bpp == BPP_32_ONLY) ? 4 : 3);
    if (keep >= 0 && keep < data_len) data_len = keep;
    for (int i = 0; i < int'(HDR_BYTES); i++) begin
      case (i)
        0:            b = 8'h42;
        1:            b = 8'h4D;
        HDR_WIDTH_LO: b = w[7:0];
        HDR_WIDTH_HI: b = w[15:8];
        HDR_HGT_LO:   b = h[7:0];
        HDR_HGT_HI:   b = h[15:8];
        HDR_BPP_LO:   b = bpp[7:0];
        HDR_BPP_HI:   b = bpp[15:8];
        default:      b = pick_byte();
      endcase
      push_byte(b, mark && i == 0);
    end
    for (longint i = 0; i < data_len; i++) push_byte(pick_byte(), 1'b0);
    for (int i = 0; i < tail; i++) push_byte(pick_byte(), 1'b0);
    files_sent++;
  endfunction

  // Mostly well-formed small files; some cut short, empty, huge or unmarked
  function automatic void queue_random_bmp();
    int pick, w, h, bpp, full;
    pick = $urandom_range(99, 0);
    w    = $urandom_range(8, 1);
    h    = $urandom_range(6, 1);
    if ($urandom_range(9, 0) == 0) begin
      w = $urandom_range(40, 9);
      h = $urandom_range(2, 1);
    end
    case ($urandom_range(9, 0))
      0:          bpp = BPP_32_HIGH;
      1:          bpp = $urandom_range(65535, 0);
      2, 3, 4, 5: bpp = BPP_32_ONLY;
      default:    bpp = BPP_24;
    endcase
    full = w * h * ((bpp == BPP_32_ONLY) ? 4 : 3);
    if (pick < 70) begin
      queue_bmp(w, h, bpp, 1'b1, -1, ($urandom_range(4, 0) == 0) ? $urandom_range(5, 1) : 0);
    end else if (pick < 80) begin
      queue_bmp(w, h, bpp, 1'b1, $urandom_range(full - 1, 0), 0);
    end else if (pick < 87) begin
      if ($urandom_range(1, 0)) w = 0;
      else h = 0;
      queue_bmp(w, h, bpp, 1'b1, -1, $urandom_range(12, 0));
    end else if (pick < 93) begin
      queue_bmp($urandom_range(65535, 0), $urandom_range(65535, 0), bpp, 1'b1,
                $urandom_range(30, 0), 0);
    end else begin
      queue_bmp(w, h, bpp, 1'b0, -1, 0);
    end
  endfunction

  function automatic void flag_write_error(input string field, input int unsigned want,
                                           input int unsigned got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endfunction

  // Register write; only issued while nothing is in flight
  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_ORIGIN_X) org_x = ORIGIN_X_W'(val);
    else org_y = ORIGIN_Y_W'(val);
  endtask

  task automatic set_origin(input int ox, input int oy);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    settings_used++;
  endtask

  // Wait for every byte to be taken and every write to come out, then idle for the TAIL_GAP margin
  task automatic settle();
    int waited;
    waited = 0;
    while ((bytes_to_send.size() != 0 || bytes_taken != bytes_queued ||
            pixel_writes_due.size() != 0) && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_GAP) @(posedge clk);
  endtask

  task automatic set_mix(input idle_mix_t mix);
    case (mix)
      MIX_SEND: begin send_idle_pct = IDLE_PCT; recv_stall_pct = 0;        end
      MIX_RECV: begin send_idle_pct = 0;        recv_stall_pct = IDLE_PCT; end
      MIX_BOTH: begin send_idle_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
      default:  begin send_idle_pct = 0;        recv_stall_pct = 0;        end
    endcase
  endtask

  // Byte driver: take acceptances into the parser, then offer the next byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        parse_file_byte(in_bus.file_byte, in_bus.start_of_file);
        bytes_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_byte = bytes_to_send.pop_front();
          in_bus.valid         <= 1'b1;
          in_bus.file_byte     <= next_byte.data;
          in_bus.start_of_file <= next_byte.sof;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold: counts down its cycles once requested
  always @(posedge clk) begin
    if (hold_seen_cnt != hold_req_cnt) begin
      hold_seen_cnt = hold_req_cnt;
      hold_left     = LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    hold_on <= (hold_left > 0);
  end

  // Write monitor: check each accepted write, drive ready with stalls and long holds
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen_write.index = out_bus.pixel_index;
      seen_write.color = out_bus.color;
      seen_write.last  = out_bus.last_pixel;
      if (pixel_writes_due.size() == 0) begin
        flag_write_error("unexpected write index", 0, seen_write.index);
      end else begin
        due_write = pixel_writes_due.pop_front();
        if (seen_write.index !== due_write.index)
          flag_write_error("pixel_index", due_write.index, seen_write.index);
        if (seen_write.color !== due_write.color)
          flag_write_error("color", due_write.color, seen_write.color);
        if (seen_write.last !== due_write.last)
          flag_write_error("last_pixel", due_write.last, seen_write.last);
        pixels_checked++;
      end
    end
    if (hold_on) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int        ox, oy, phase_start;
    idle_mix_t mix;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.file_byte     = '0;
    in_bus.start_of_file = 1'b0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_ORIGIN_X;
    cfg_bus.data         = '0;
    org_x                = '0;
    org_y                = '0;
    clear_parse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed files at the reset origin
    set_mix(MIX_NONE);
    queue_bmp(2, 2, BPP_24, 1'b0, -1, 0);       // no start mark after reset
    queue_bmp(3, 2, BPP_32_ONLY, 1'b1, -1, 4);  // pad byte per pixel, trailing bytes
    queue_bmp(0, 3, BPP_24, 1'b1, -1, 9);       // zero width: data ignored
    queue_bmp(2, 0, BPP_24, 1'b1, -1, 6);       // zero height: data ignored
    queue_bmp(2, 1, BPP_32_HIGH, 1'b1, -1, 0);  // not exactly 32: three bytes per pixel
    queue_bmp(4, 4, BPP_24, 1'b1, 10, 0);       // cut short, restarted by next mark
    queue_bmp(1, 1, BPP_24, 1'b1, -1, 0);
    settle();

    // Far corner: only the top-left image pixel lands, at the last framebuffer word
    set_origin(SCR_W - 1, SCR_H - 1);
    queue_bmp(3, 3, BPP_32_ONLY, 1'b1, -1, 0);
    settle();

    // Image straddles right and bottom edges
    set_origin(790, 475);
    queue_bmp(12, 6, BPP_24, 1'b1, -1, 0);
    settle();

    // Random files over idle mixes and origin settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      mix = idle_mix_t'(p % 4);
      set_mix(mix);
      if (p == 0) begin
        ox = 5;
        oy = 5;
      end else begin
        case ($urandom_range(3, 0))
          0:       ox = 0;
          1:       ox = SCR_W - 1;
          2:       ox = $urandom_range(SCR_W - 1, SCR_W - 20);
          default: ox = $urandom_range(SCR_W - 1, 0);
        endcase
        case ($urandom_range(3, 0))
          0:       oy = 0;
          1:       oy = SCR_H - 1;
          2:       oy = $urandom_range(SCR_H - 1, SCR_H - 8);
          default: oy = $urandom_range(SCR_H - 1, 0);
        endcase
      end
      set_origin(ox, oy);
      // first phase: hold the output off while bytes keep coming, so input backs up
      if (p == 0) hold_req_cnt++;
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) queue_random_bmp();
      settle();
    end

    if (pixel_writes_due.size() != 0) begin
      errors += pixel_writes_due.size();
      $display("%0d pixel writes never arrived", pixel_writes_due.size());
    end
    $display("%0d files, %0d bytes taken, %0d pixel writes checked, %0d mismatches",
             files_sent, bytes_taken, pixels_checked, errors);
    $display("%0d origin settings, idle and stall mixes plus one long output hold",
             settings_used);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
